[hw/rtl/qyrc_pkg.sv]
// ----------------------------------------------------------------------------
// qyrc_pkg - shared types and constants for the quaternion yaw range check
// Widths, CORDIC angle table and the data word handed along the cell chain.
// ----------------------------------------------------------------------------
package qyrc_pkg;

	localparam int CORDIC_STAGES = 16;   // 8 .. 24
	localparam int QW  = 16;             // quaternion, yaw and bound width
	localparam int CW  = 36;             // CORDIC vector width (S, C scaled by 2^30)
	localparam int AW  = 26;             // angle accumulator, degrees * 2^16
	localparam int TIW = 5;              // index width of the 24-entry angle table
	localparam int YW  = 17;             // rounded yaw before the wrap

	localparam logic signed [CW-1:0] ONE_Q30       = CW'(2**30);
	localparam logic signed [AW-1:0] ANG_HALF_TURN = AW'(11796480);
	localparam logic signed [AW-1:0] ROUND_BIAS    = AW'(256);
	localparam int                   ROUND_SHIFT   = 9;
	localparam logic signed [YW-1:0] YAW_HALF      = YW'(23040);
	localparam logic signed [YW-1:0] YAW_FULL      = YW'(46080);

	// configuration register indexes
	localparam logic REG_MIN_YAW = 1'b0;
	localparam logic REG_MAX_YAW = 1'b1;

	localparam logic signed [QW-1:0] MIN_YAW_RST = -16'sd23040;
	localparam logic signed [QW-1:0] MAX_YAW_RST = 16'sd23039;

	typedef struct packed {
		logic                 zero;   // both atan2 arguments zero
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] acc;
	} cdc_t;

	// round(atan(2^-i) in degrees * 2^16)
	function automatic logic signed [AW-1:0] atan_q16(input logic [TIW-1:0] i);
		logic signed [AW-1:0] r;
		unique case (i)
			5'd0:  r = AW'(2949120);
			5'd1:  r = AW'(1740967);
			5'd2:  r = AW'(919879);
			5'd3:  r = AW'(466945);
			5'd4:  r = AW'(234379);
			5'd5:  r = AW'(117304);
			5'd6:  r = AW'(58666);
			5'd7:  r = AW'(29335);
			5'd8:  r = AW'(14668);
			5'd9:  r = AW'(7334);
			5'd10: r = AW'(3667);
			5'd11: r = AW'(1833);
			5'd12: r = AW'(917);
			5'd13: r = AW'(458);
			5'd14: r = AW'(229);
			5'd15: r = AW'(115);
			5'd16: r = AW'(57);
			5'd17: r = AW'(29);
			5'd18: r = AW'(14);
			5'd19: r = AW'(7);
			5'd20: r = AW'(4);
			5'd21: r = AW'(2);
			5'd22: r = AW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/qyrc_prep.sv]
// ----------------------------------------------------------------------------
// qyrc_prep - atan2 argument forming and half-plane pre-rotation
// Three stages: products, S/C sums, negation into the right half plane.
// ----------------------------------------------------------------------------
module qyrc_prep
	import qyrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [QW-1:0] quat_w,
	input  logic signed [QW-1:0] quat_x,
	input  logic signed [QW-1:0] quat_y,
	input  logic signed [QW-1:0] quat_z,
	output cdc_t                 q,
	output logic                 q_valid,
	input  logic                 take_next
);

	logic signed [2*QW-1:0] p_wz_s1, p_xy_s1, p_yy_s1, p_zz_s1;
	logic                   v_s1, v_s2, v_s3;
	logic signed [CW-1:0]   s_s2, c_s2;
	logic                   zero_s2;
	cdc_t                   d_s3;
	logic                   en1, en2, en3;
	logic signed [CW-1:0]   s_sum, c_sum;

	assign en3      = !v_s3 || take_next;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_yy_s1 <= quat_y * quat_y;
			p_zz_s1 <= quat_z * quat_z;
		end
	end

	// S = 2(wz + xy), C = 2^30 - 2(yy + zz)
	assign s_sum = (CW'(p_wz_s1) + CW'(p_xy_s1)) <<< 1;
	assign c_sum = ONE_Q30 - ((CW'(p_yy_s1) + CW'(p_zz_s1)) <<< 1);

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			s_s2    <= s_sum;
			c_s2    <= c_sum;
			zero_s2 <= (s_sum == '0) && (c_sum == '0);
		end
	end

	// left half plane: rotate by 180 degrees, start the angle at +/-180
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			d_s3.zero <= zero_s2;
			if (c_s2[CW-1]) begin
				d_s3.x   <= -c_s2;
				d_s3.y   <= -s_s2;
				d_s3.acc <= s_s2[CW-1] ? -ANG_HALF_TURN : ANG_HALF_TURN;
			end else begin
				d_s3.x   <= c_s2;
				d_s3.y   <= s_s2;
				d_s3.acc <= '0;
			end
		end
	end

	assign q       = d_s3;
	assign q_valid = v_s3;

	a_x_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> !d_s3.x[CW-1])
		else $error("pre-rotated x is negative");

endmodule

[hw/rtl/qyrc_cell.sv]
// ----------------------------------------------------------------------------
// qyrc_cell - one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-stage) and registers the vector.
// ----------------------------------------------------------------------------
module qyrc_cell
	import qyrc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic [TIW-1:0] stage,
	input  cdc_t           d,
	input  logic           d_valid,
	output logic           take,
	output cdc_t           q,
	output logic           q_valid,
	input  logic           take_next
);

	cdc_t                 q_q;
	logic                 v_q;
	cdc_t                 nxt;
	logic signed [CW-1:0] dx, dy;
	logic signed [AW-1:0] ang;

	assign take = !v_q || take_next;
	assign dx   = d.y >>> stage;
	assign dy   = d.x >>> stage;
	assign ang  = atan_q16(stage);

	always_comb begin
		nxt.zero = d.zero;
		if (!d.y[CW-1]) begin
			nxt.x   = d.x + dx;
			nxt.y   = d.y - dy;
			nxt.acc = d.acc + ang;
		end else begin
			nxt.x   = d.x - dx;
			nxt.y   = d.y + dy;
			nxt.acc = d.acc - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && d_valid) q_q <= nxt;
	end

	assign q       = q_q;
	assign q_valid = v_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && !take_next |=> v_q && $stable(q_q))
		else $error("cell dropped or changed a stalled item");

endmodule

[hw/rtl/qyrc_post.sv]
// ----------------------------------------------------------------------------
// qyrc_post - yaw rounding, wrap and range compare
// Rounds the angle to 1/128 degree, wraps into [-180, 180), registers output.
// ----------------------------------------------------------------------------
module qyrc_post
	import qyrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cdc_t                 d,
	input  logic                 d_valid,
	output logic                 take,
	input  logic signed [QW-1:0] min_yaw,
	input  logic signed [QW-1:0] max_yaw,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [QW-1:0] yaw_angle,
	output logic                 yaw_ok
);

	logic signed [AW-1:0] acc_r;
	logic signed [YW-1:0] yaw_raw, yaw_wrap;
	logic signed [QW-1:0] yaw;
	logic                 v_q;
	logic signed [QW-1:0] yaw_q;
	logic                 rng_q;

	assign take    = !v_q || out_ready;
	assign acc_r   = (d.acc + ROUND_BIAS) >>> ROUND_SHIFT;
	assign yaw_raw = acc_r[YW-1:0];

	always_comb begin
		priority if (yaw_raw >= YAW_HALF) begin
			yaw_wrap = yaw_raw - YAW_FULL;
		end else if (yaw_raw < -YAW_HALF) begin
			yaw_wrap = yaw_raw + YAW_FULL;
		end else begin
			yaw_wrap = yaw_raw;
		end
	end

	assign yaw = d.zero ? '0 : yaw_wrap[QW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && d_valid) begin
			yaw_q <= yaw;
			rng_q <= (min_yaw <= yaw) && (yaw <= max_yaw);
		end
	end

	assign out_valid = v_q;
	assign yaw_angle = yaw_q;
	assign yaw_ok    = rng_q;

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> (yaw_q >= -16'sd23040) && (yaw_q <= 16'sd23039))
		else $error("yaw outside [-180, 180)");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q |-> take)
		else $error("empty output stage refuses an item");

endmodule

[hw/rtl/quaternion_yaw_range_check_core.sv]
// ----------------------------------------------------------------------------
// quaternion_yaw_range_check_core - yaw from a quaternion, checked against bounds
// Unrolled CORDIC atan2 cell chain, one item per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one quaternion quat_w..quat_z in
//   signed Q1.15. Output channel (out_valid/out_ready) returns yaw_angle in
//   1/128 degree, wrapped into [-180, 180), and yaw_ok, set when
//   min_yaw <= yaw_angle <= max_yaw.
//   Bounds are written through cfg_we/cfg_index/cfg_data: index 0 is min_yaw,
//   index 1 is max_yaw. Write them only while no item is in flight.
//   Stages: three forming stages, one per CORDIC cell, one output register.
//   Throughput is one item per cycle while out_ready stays high, set by the
//   pipelined cell chain.
//   When the receiver stalls, items pile up in the empty stages; in_ready
//   falls only once every stage holds an item.
//   Reset empties the pipeline and loads min_yaw = -23040, max_yaw = 23039.
// ----------------------------------------------------------------------------
module quaternion_yaw_range_check_core
	import qyrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [QW-1:0] quat_w,
	input  logic signed [QW-1:0] quat_x,
	input  logic signed [QW-1:0] quat_y,
	input  logic signed [QW-1:0] quat_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [QW-1:0] yaw_angle,
	output logic                 yaw_ok,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [QW-1:0]        cfg_data
);

	logic signed [QW-1:0] min_yaw_q, max_yaw_q;
	cdc_t                 chain  [CORDIC_STAGES+1];
	logic                 vchain [CORDIC_STAGES+1];
	logic                 tchain [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_yaw_q <= MIN_YAW_RST;
			max_yaw_q <= MAX_YAW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_YAW: min_yaw_q <= signed'(cfg_data);
				REG_MAX_YAW: max_yaw_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	qyrc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.q         (chain[0]),
		.q_valid   (vchain[0]),
		.take_next (tchain[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		qyrc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage     (TIW'(i)),
			.d         (chain[i]),
			.d_valid   (vchain[i]),
			.take      (tchain[i]),
			.q         (chain[i+1]),
			.q_valid   (vchain[i+1]),
			.take_next (tchain[i+1])
		);
	end

	qyrc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.d         (chain[CORDIC_STAGES]),
		.d_valid   (vchain[CORDIC_STAGES]),
		.take      (tchain[CORDIC_STAGES]),
		.min_yaw   (min_yaw_q),
		.max_yaw   (max_yaw_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.yaw_angle (yaw_angle),
		.yaw_ok    (yaw_ok)
	);

endmodule

[tb/quaternion_yaw_range_check_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_yaw_range_check_core_tb - self-checking bench for the yaw check
// Drives quaternions through the valid/ready input and predicts each yaw and
// yaw_ok flag with a local CORDIC model. Each result is checked in order.
// Covers reset bounds, written bounds (extreme, crossed, equal), back-pressure
// and random traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module quaternion_yaw_range_check_core_tb
	import qyrc_pkg::*;
();

	localparam int     PIPE_LATENCY   = CORDIC_STAGES + 4;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     HOLD_LEN       = 150;
	localparam longint HALF_TURN_Q16  = 64'sd11796480;
	localparam longint ATAN_DEG_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct packed {
		logic signed [QW-1:0] w;
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
	} quat_t;

	typedef struct {
		logic signed [QW-1:0] yaw;
		logic                 yaw_ok;
	} yaw_check_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [QW-1:0] quat_w;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [QW-1:0] yaw_angle;
	logic                 yaw_ok;
	logic                 cfg_we;
	logic                 cfg_index;
	logic [QW-1:0]        cfg_data;

	logic signed [QW-1:0] min_bound;
	logic signed [QW-1:0] max_bound;
	yaw_check_t           yaw_results_due[$];
	int                   mismatch_count;
	int                   src_idle_pct;
	int                   snk_stall_pct;
	bit                   hold_request;

	quaternion_yaw_range_check_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.quat_w    (quat_w),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.yaw_angle (yaw_angle),
		.yaw_ok    (yaw_ok),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// yaw = atan2(2(wz+xy), 1-2(y^2+z^2)) by vectoring CORDIC, 1/128 deg, wrapped
	function automatic logic signed [QW-1:0] predict_yaw(input quat_t q);
		longint s, c, acc, dx, dy, yaw;
		s = 2 * (longint'(q.w) * longint'(q.z) + longint'(q.x) * longint'(q.y));
		c = (64'sd1 <<< 30) - 2 * (longint'(q.y) * longint'(q.y)
			+ longint'(q.z) * longint'(q.z));
		acc = 0;
		if (s == 0 && c == 0)
			return '0;
		// left half plane: fold over and start from +/-180
		if (c < 0) begin
			acc = (s >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
			c = -c;
			s = -s;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = s >>> i;
			dy = c >>> i;
			if (s >= 0) begin
				c = c + dx;
				s = s - dy;
				acc = acc + ATAN_DEG_Q16[i];
			end else begin
				c = c - dx;
				s = s + dy;
				acc = acc - ATAN_DEG_Q16[i];
			end
		end
		yaw = (acc + 256) >>> 9;
		if (yaw >= 23040)
			yaw = yaw - 46080;
		else if (yaw < -23040)
			yaw = yaw + 46080;
		return QW'(yaw);
	endfunction

	function automatic quat_t make_quat(input int w, input int x, input int y, input int z);
		quat_t q;
		q.w = QW'(w);
		q.x = QW'(x);
		q.y = QW'(y);
		q.z = QW'(z);
		return q;
	endfunction

	function automatic logic signed [QW-1:0] sat16(input int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return QW'(v);
	endfunction

	function automatic logic signed [QW-1:0] corner_value();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return -16'sd32767;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			5: return 16'sd16384;
			6: return -16'sd16384;
			default: return 16'sd32767;
		endcase
	endfunction

	function automatic quat_t random_quat();
		quat_t q;
		real   half_ang, mag;
		int    pick;
		pick = $urandom_range(0, 9);
		q = quat_t'({$urandom, $urandom});
		if (pick >= 4 && pick <= 6) begin
			// mostly pure yaw rotation, some tilt, random scale and sign
			half_ang = $urandom_range(0, 71999) * 3.14159265358979 / 72000.0;
			mag = 500.0 + $urandom_range(0, 32267);
			if ($urandom_range(0, 1))
				mag = -mag;
			q.w = sat16($rtoi(mag * $cos(half_ang)));
			q.z = sat16($rtoi(mag * $sin(half_ang)));
			q.x = sat16(int'($urandom_range(0, 400)) - 200);
			q.y = sat16(int'($urandom_range(0, 400)) - 200);
		end else if (pick == 7) begin
			q = make_quat(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4,
				int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4);
		end else if (pick == 8) begin
			q.w = corner_value();
			q.x = corner_value();
			q.y = corner_value();
			q.z = corner_value();
		end else if (pick == 9) begin
			if ($urandom_range(0, 1)) q.w = '0;
			if ($urandom_range(0, 1)) q.x = '0;
			if ($urandom_range(0, 1)) q.y = '0;
			if ($urandom_range(0, 1)) q.z = '0;
		end
		return q;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_quat(input quat_t q);
		yaw_check_t due;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		quat_w   <= q.w;
		quat_x   <= q.x;
		quat_y   <= q.y;
		quat_z   <= q.z;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		due.yaw = predict_yaw(q);
		due.yaw_ok = (min_bound <= due.yaw) && (due.yaw <= max_bound);
		yaw_results_due.push_back(due);
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (yaw_results_due.size() != 0)
			@(negedge clk);
		repeat (2 * PIPE_LATENCY) @(negedge clk);
	endtask

	task automatic write_bound(input logic idx, input logic signed [QW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_MIN_YAW)
			min_bound = value;
		else
			max_bound = value;
	endtask

	task automatic apply_bounds(input int lo, input int hi);
		drain_pipeline();
		write_bound(REG_MIN_YAW, QW'(lo));
		write_bound(REG_MAX_YAW, QW'(hi));
	endtask

	// reset bounds; extremes and the special cases of the yaw path
	task automatic test_directed_cases();
		send_quat(make_quat(0, 0, 0, 0));
		send_quat(make_quat(32767, 0, 0, 0));
		send_quat(make_quat(-32768, 0, 0, 0));
		send_quat(make_quat(0, 0, 0, 32767));       // +180 wraps to -180
		send_quat(make_quat(0, 0, 0, -32768));
		send_quat(make_quat(0, 0, 32767, 0));
		send_quat(make_quat(0, -32768, -32768, 0));
		send_quat(make_quat(1, 0, 0, -32767));      // just above -180
		send_quat(make_quat(23170, 0, 0, 23170));
		send_quat(make_quat(23170, 0, 0, -23170));
		send_quat(make_quat(0, 0, 16384, 16384));   // both atan2 args zero
		send_quat(make_quat(-300, 300, 16384, 16384));
		send_quat(make_quat(7, 7, -16384, 16384));
		send_quat(make_quat(32767, 32767, 32767, 32767));
		send_quat(make_quat(-32768, -32768, -32768, -32768));
		send_quat(make_quat(32767, -32768, 32767, -32768));
		send_quat(make_quat(-32768, 32767, -32768, 32767));
		send_quat(make_quat(1, 0, 0, -1));
		send_quat(make_quat(-1, 0, 0, 1));
		send_quat(make_quat(0, 0, 1, 0));
		send_quat(make_quat(3, -2, 1, 5));          // unnormalized, tiny
		drain_pipeline();
	endtask

	task automatic check_bounds_setting(input int lo, input int hi);
		apply_bounds(lo, hi);
		send_quat(make_quat(32767, 0, 0, 0));       // yaw 0
		send_quat(make_quat(0, 0, 0, 32767));       // yaw -23040
		repeat (20) send_quat(random_quat());
	endtask

	task automatic test_bound_settings();
		check_bounds_setting(-23040, 23039);
		check_bounds_setting(0, 0);
		check_bounds_setting(100, -100);            // crossed: never in range
		check_bounds_setting(-32768, 32767);
		check_bounds_setting(32767, -32768);
		check_bounds_setting(-23040, -23040);
		check_bounds_setting(23039, 23039);
		check_bounds_setting(-11520, 11520);
		drain_pipeline();
	endtask

	// sink holds off while the source keeps offering; the pipe fills up
	task automatic test_output_backpressure();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_request  = 1'b1;
		repeat (3 * PIPE_LATENCY) send_quat(random_quat());
		drain_pipeline();
	endtask

	task automatic test_pause_until_empty();
		src_idle_pct  = 19;
		snk_stall_pct = 19;
		repeat (30) send_quat(random_quat());
		drain_pipeline();
		repeat (30) send_quat(random_quat());
		drain_pipeline();
	endtask

	task automatic test_random_traffic(input int count, input int src_pct, input int snk_pct);
		int a, b;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				a = int'($urandom_range(0, 46079)) - 23040;
				b = int'($urandom_range(0, 46079)) - 23040;
				if (a > b && $urandom_range(0, 9) != 0)
					apply_bounds(b, a);
				else
					apply_bounds(a, b);
			end
			send_quat(random_quat());
		end
		drain_pipeline();
	endtask

	initial begin : sink_driver
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < snk_stall_pct) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// sample at the rising edge, compare at the falling edge once all
	// expectations of that edge are queued
	initial begin : result_checker
		logic                 took;
		logic                 bad_valid;
		logic signed [QW-1:0] got_yaw;
		logic                 got_flag;
		yaw_check_t           due;
		forever begin
			@(posedge clk);
			bad_valid = arst_n && $isunknown(out_valid);
			took      = arst_n && (out_valid === 1'b1) && out_ready;
			got_yaw   = yaw_angle;
			got_flag  = yaw_ok;
			@(negedge clk);
			if (bad_valid)
				report_mismatch("out_valid unknown");
			if (took) begin
				if (yaw_results_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result yaw %0d", got_yaw));
				end else begin
					due = yaw_results_due.pop_front();
					if (got_yaw !== due.yaw)
						report_mismatch($sformatf("yaw_angle %0d, want %0d",
							got_yaw, due.yaw));
					if (got_flag !== due.yaw_ok)
						report_mismatch($sformatf("yaw_ok %b, want %b (yaw %0d)",
							got_flag, due.yaw_ok, due.yaw));
				end
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : test_sequence
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		quat_w        = '0;
		quat_x        = '0;
		quat_y        = '0;
		quat_z        = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_MIN_YAW;
		cfg_data      = '0;
		min_bound     = MIN_YAW_RST;
		max_bound     = MAX_YAW_RST;
		mismatch_count = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_request  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_bound_settings();
		test_output_backpressure();
		test_pause_until_empty();
		test_random_traffic(230, 0, 0);
		test_random_traffic(230, 76, 0);
		test_random_traffic(230, 0, 76);
		test_random_traffic(230, 19, 19);
		drain_pipeline();

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
